@@ design/speq_pkg.sv @@
package speq_pkg;

   localparam int TIME_W = 31;
   localparam int KIND_W = 8;
   localparam int JOB_W  = 16;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] event_time;
      logic [KIND_W-1:0] event_kind;
      logic [JOB_W-1:0]  job_number;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

@@ design/speq_if.sv @@
interface speq_req_if;
   import speq_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [TIME_W-1:0] event_time;
   logic [KIND_W-1:0] event_kind;
   logic [JOB_W-1:0]  job_number;

   modport source (output valid, cmd, event_time, event_kind, job_number, input ready);
   modport sink   (input valid, cmd, event_time, event_kind, job_number, output ready);
endinterface

interface speq_rsp_if #(
   parameter int COUNT_W = 5
);
   import speq_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [TIME_W-1:0]  popped_time;
   logic [KIND_W-1:0]  popped_kind;
   logic [JOB_W-1:0]   popped_job;
   logic [TIME_W-1:0]  head_time;
   logic [KIND_W-1:0]  head_kind;
   logic [JOB_W-1:0]   head_job;
   logic               is_empty;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, popped_time, popped_kind, popped_job,
                   head_time, head_kind, head_job, is_empty, entry_count,
                   input ready);
   modport sink   (input valid, status, popped_time, popped_kind, popped_job,
                   head_time, head_kind, head_job, is_empty, entry_count,
                   output ready);
endinterface

@@ design/speq_cell.sv @@
module speq_cell (
   input  logic                    clock,
   input  speq_pkg::cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    prev_keep,
   input  speq_pkg::entry_type     prev_entry,
   input  speq_pkg::entry_type     next_entry,
   output logic                    keep,
   output speq_pkg::entry_type     entry_ff,
   output speq_pkg::entry_type     entry_in
);
   import speq_pkg::*;

   // held entry stays in place when it is not later than the new key
   assign keep = occupied && (entry_ff.event_time <= ctrl.new_entry.event_time);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!keep) begin
            // first cell past the insertion point takes the new word
            entry_in = prev_keep ? ctrl.new_entry : prev_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ design/sorted_event_priority_queue.sv @@
// channel | dir | handshake   | word
// req     | in  | valid/ready | cmd, event_time, event_kind, job_number
// rsp     | out | valid/ready | status, popped_*, head_*, is_empty, entry_count
//
// one word per cycle while req.ready is high: every cell compares its key
// with the pushed key and shifts or holds in the same cycle, and the
// response appears in the output register on the next cycle.
// reset clears the count and the output valid; cell contents are not cleared.
// req.ready is low only while a response is held and rsp.ready is low.
module sorted_event_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   speq_req_if.sink       req,
   speq_rsp_if.source     rsp
);
   import speq_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0] count_ff, count_in;
   logic            fire, push_ok, pop_ok, is_full, is_pop;
   cell_ctrl_type   ctrl;
   entry_type       cell_q  [DEPTH];
   entry_type       cell_d  [DEPTH];
   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] occ;

   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   entry_type       rsp_popped_ff, rsp_popped_in;
   entry_type       rsp_head_ff, rsp_head_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic [CntW-1:0] rsp_count_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;
   assign is_pop    = (cmd_type'(req.cmd) == CMD_POP);
   assign is_full   = (count_ff == CntW'(DEPTH));
   assign push_ok   = fire && !is_pop && !is_full;
   assign pop_ok    = fire && is_pop && (count_ff != '0);

   assign ctrl.push                 = push_ok;
   assign ctrl.pop                  = pop_ok;
   assign ctrl.new_entry.event_time = req.event_time;
   assign ctrl.new_entry.event_kind = req.event_kind;
   assign ctrl.new_entry.job_number = req.job_number;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i] = (CntW'(i) < count_ff);
      speq_cell cell_i (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ[i]),
         .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
         .prev_entry (cell_q[(i == 0) ? 0 : i - 1]),
         .next_entry (cell_q[(i == DEPTH - 1) ? i : i + 1]),
         .keep       (keep[i]),
         .entry_ff   (cell_q[i]),
         .entry_in   (cell_d[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_status_in = ST_OK;
      if (fire && !is_pop && is_full) begin
         rsp_status_in = ST_FULL;
      end else if (fire && is_pop && (count_ff == '0)) begin
         rsp_status_in = ST_EMPTY;
      end
      rsp_popped_in = pop_ok ? cell_q[0] : '0;
      rsp_empty_in  = (count_in == '0);
      rsp_head_in   = rsp_empty_in ? '0 : cell_d[0];
      rsp_valid_in  = fire ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_head_ff   <= rsp_head_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.popped_time = rsp_popped_ff.event_time;
   assign rsp.popped_kind = rsp_popped_ff.event_kind;
   assign rsp.popped_job  = rsp_popped_ff.job_number;
   assign rsp.head_time   = rsp_head_ff.event_time;
   assign rsp.head_kind   = rsp_head_ff.event_kind;
   assign rsp.head_job    = rsp_head_ff.job_number;
   assign rsp.is_empty    = rsp_empty_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule

@@ design/speq_checker.sv @@
module speq_checker #(
   parameter int CountW = 5
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [30:0]       rsp_popped_time,
   input logic [30:0]       rsp_head_time,
   input logic              rsp_is_empty,
   input logic [CountW-1:0] rsp_count
);
   import speq_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
      else $error("rsp word changed while stalled");

   // each accepted request yields a response on the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)) &&
                    (!rsp_is_empty || rsp_head_time == '0))
      else $error("empty flag, count or head disagree");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_popped_time == '0)
      else $error("pop on empty reported wrongly");

endmodule

bind sorted_event_priority_queue speq_checker #(
   .CountW($clog2(DEPTH + 1))
) checker_i (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_popped_time (rsp.popped_time),
   .rsp_head_time   (rsp.head_time),
   .rsp_is_empty    (rsp.is_empty),
   .rsp_count       (rsp.entry_count)
);

@@ bench/sorted_event_priority_queue_checker.sv @@
`timescale 1ns / 1ps

module sorted_event_priority_queue_checker #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   speq_req_if  req,
   speq_rsp_if  rsp,
   output int   fail_count,
   output int   outstanding
);
   import speq_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef struct {
      status_type         status;
      entry_type          popped;
      entry_type          head;
      logic               is_empty;
      logic [COUNT_W-1:0] entry_count;
   } queue_result_type;

   // sorted copy of the queue, earliest entry in slot 0
   entry_type        sorted_slots[DEPTH];
   int               held;
   queue_result_type awaited_words[$];

   function automatic queue_result_type apply_word(cmd_type op, entry_type item);
      queue_result_type r;
      int               pos;
      r.status   = ST_OK;
      r.popped   = '0;
      r.head     = '0;
      r.is_empty = 1'b1;
      if (op == CMD_PUSH) begin
         if (held >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // equal times stay in arrival order
            pos = 0;
            while (pos < held && sorted_slots[pos].event_time <= item.event_time) pos++;
            for (int i = held; i > pos; i--) sorted_slots[i] = sorted_slots[i-1];
            sorted_slots[pos] = item;
            held++;
         end
      end else begin
         if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.popped = sorted_slots[0];
            for (int i = 1; i < held; i++) sorted_slots[i-1] = sorted_slots[i];
            held--;
         end
      end
      if (held > 0) begin
         r.head     = sorted_slots[0];
         r.is_empty = 1'b0;
      end
      r.entry_count = COUNT_W'(held);
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      entry_type        item;
      if (reset) begin
         held = 0;
         awaited_words.delete();
      end else begin
         // a response seen at this edge belongs to an earlier request
         if (rsp.valid && rsp.ready) begin
            if (awaited_words.size() == 0) begin
               fail_count++;
               $display("%0t: response word with none expected, status %0h count %0d",
                        $time, rsp.status, rsp.entry_count);
            end else begin
               want = awaited_words.pop_front();
               check_field("status", want.status, rsp.status);
               check_field("popped_time", want.popped.event_time, rsp.popped_time);
               check_field("popped_kind", want.popped.event_kind, rsp.popped_kind);
               check_field("popped_job", want.popped.job_number, rsp.popped_job);
               check_field("head_time", want.head.event_time, rsp.head_time);
               check_field("head_kind", want.head.event_kind, rsp.head_kind);
               check_field("head_job", want.head.job_number, rsp.head_job);
               check_field("is_empty", want.is_empty, rsp.is_empty);
               check_field("entry_count", want.entry_count, rsp.entry_count);
            end
         end
         if (req.valid && req.ready) begin
            item.event_time = req.event_time;
            item.event_kind = req.event_kind;
            item.job_number = req.job_number;
            awaited_words.push_back(apply_word(cmd_type'(req.cmd), item));
         end
      end
      outstanding <= awaited_words.size();
   end

endmodule

@@ bench/sorted_event_priority_queue_test.sv @@
`timescale 1ns / 1ps

module sorted_event_priority_queue_test;
   import speq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int COUNT_W      = $clog2(DEPTH + 1);
   localparam int RANDOM_WORDS = 400;
   localparam int HOLD_CYCLES  = 80;
   localparam int LIMIT_CYCLES = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on = 1'b1;
   logic hold_request = 1'b0;
   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;

   speq_req_if                    req_chan ();
   speq_rsp_if #(.COUNT_W(COUNT_W)) rsp_chan ();

   sorted_event_priority_queue #(.DEPTH(DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   sorted_event_priority_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("sorted_event_priority_queue: mismatch");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      int hold_left;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
               rsp_chan.ready <= 1'b0;
               hold_left--;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= !(idle_on && $urandom_range(99) < 23);
      end
   end

   task automatic send_word(cmd_type op, logic [TIME_W-1:0] t,
                            logic [KIND_W-1:0] k, logic [JOB_W-1:0] j);
      while (idle_on && $urandom_range(99) < 23) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= op;
      req_chan.event_time <= t;
      req_chan.event_kind <= k;
      req_chan.job_number <= j;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      int mode;
      mode = $urandom_range(9);
      if (mode < 4) return TIME_W'($urandom);
      // narrow range gives many equal keys
      if (mode < 8) return TIME_W'($urandom_range(7));
      case ($urandom_range(2))
         0: return '0;
         1: return '1;
         default: return {{(TIME_W-1){1'b1}}, 1'b0};
      endcase
   endfunction

   initial begin
      int push_pct;
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= CMD_PUSH;
      req_chan.event_time <= '0;
      req_chan.event_kind <= '0;
      req_chan.job_number <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, ties, fill, refused push, drain a few
      send_word(CMD_POP, '1, '1, '1);
      send_word(CMD_PUSH, '1, '1, '1);
      send_word(CMD_PUSH, '0, '0, '0);
      send_word(CMD_PUSH, TIME_W'(5), 8'h11, 16'h1111);
      send_word(CMD_PUSH, TIME_W'(5), 8'h22, 16'h2222);
      for (int i = 0; i < DEPTH - 4; i++)
         send_word(CMD_PUSH, TIME_W'(i * 3), KIND_W'(i), JOB_W'(16'h8000 + i));
      send_word(CMD_PUSH, TIME_W'(1), 8'hAA, 16'h5555);
      repeat (3) send_word(CMD_POP, '0, '0, '0);

      push_pct = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 24 == 0) begin
            case ($urandom_range(3))
               0: push_pct = 15;
               1: push_pct = 50;
               2: push_pct = 85;
               default: push_pct = 100;
            endcase
         end
         idle_on <= !(n >= 150 && n < 250);
         if (n == 60 || n == 300) hold_request = 1'b1;
         send_word($urandom_range(99) < push_pct ? CMD_PUSH : CMD_POP, pick_time(),
                   KIND_W'($urandom), JOB_W'($urandom));
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("sorted_event_priority_queue: match");
      end else begin
         $display("sorted_event_priority_queue: mismatch");
      end
      $finish;
   end

endmodule
